/* hdl/rsso_pkg.sv */
// shared types, constants and a helper function for the ramped stereo sine oscillator
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package rsso_pkg;

  // build-time sizing
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_RAMP_SHIFT  = 12;

  // field widths
  localparam int STEP_W  = 32;
  localparam int LEVEL_W = 16;
  localparam int PAN_W   = 16;
  localparam int OUT_W   = 16;
  localparam int CFG_W   = 4;

  localparam int TICK_W    = MAX_RAMP_SHIFT;
  localparam int SHIFT_W   = $clog2(MAX_RAMP_SHIFT + 1);
  localparam int QUAD_BITS = TABLE_ADDR_BITS - 2;
  localparam int GAIN_W    = PAN_W + 2;

  // polynomial arithmetic, Q30 values
  localparam int FRAC  = 30;
  localparam int VAL_W = 31;
  localparam logic [VAL_W-1:0] ONE_Q30     = VAL_W'(1) << FRAC;
  localparam logic [VAL_W-1:0] HORNER_SEED = VAL_W'(3864);
  localparam int HORNER_TERMS = 5;
  localparam int CNT_W        = $clog2(HORNER_TERMS);

  // shared multiplier
  localparam int MUL_W  = (SAMPLE_BITS + LEVEL_W + 1 > 33) ? SAMPLE_BITS + LEVEL_W + 1 : 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam int SINE_AMP  = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int OUT_SHIFT = SAMPLE_BITS - 1 + 15;
  localparam int HALF_Q15  = 16384;

  // reset values
  localparam logic [STEP_W-1:0]  RESET_STEP       = STEP_W'(44739243);
  localparam logic [LEVEL_W-1:0] RESET_LEVEL      = LEVEL_W'(4096);
  localparam logic [CFG_W-1:0]   RESET_RAMP_SHIFT = CFG_W'(9);

  typedef enum logic [3:0] {
    S_IDLE,
    S_X2,
    S_HORNER,
    S_Y,
    S_AMP,
    S_SL,
    S_MUL_L,
    S_MUL_R,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_X2,
    MUL_HORNER,
    MUL_Y,
    MUL_AMP,
    MUL_SL,
    MUL_LEFT,
    MUL_RIGHT
  } mul_sel_t;

  typedef struct packed {
    logic             accept;
    logic             incr_calc;
    logic             ramp_update;
    logic             phase_advance;
    mul_sel_t         mul_sel;
    logic [CNT_W-1:0] coef_idx;
    logic             sat_left;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // odd taylor coefficients of sin(pi/2 x), Q30, highest order first after the seed
  function automatic logic [VAL_W-1:0] horner_coef(input logic [CNT_W-1:0] idx);
    logic [VAL_W-1:0] c;
    case (idx)
      3'd0:    c = VAL_W'(172272);
      3'd1:    c = VAL_W'(5026989);
      3'd2:    c = VAL_W'(85569306);
      3'd3:    c = VAL_W'(693598668);
      3'd4:    c = VAL_W'(1686629713);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/rsso_in_if.sv */
// input channel: one sample tick with targets and pan
// depends on rsso_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rsso_in_if import rsso_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STEP_W-1:0]        target_step;
  logic [LEVEL_W-1:0]       target_level;
  logic signed [PAN_W-1:0]  pan_position;

  modport source (output valid, output target_step, output target_level,
                  output pan_position, input ready);
  modport sink   (input valid, input target_step, input target_level,
                  input pan_position, output ready);
endinterface

`default_nettype wire

/* hdl/rsso_out_if.sv */
// result channel: one stereo sample pair
// depends on rsso_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rsso_out_if import rsso_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  left_sample;
  logic signed [OUT_W-1:0]  right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

/* hdl/rsso_ctrl.sv */
// sequencer for the oscillator: steps one tick through the shared multiplier
// depends on rsso_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsso_ctrl import rsso_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] horner_cnt_r, horner_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      horner_cnt_r <= '0;
    end else begin
      state_r      <= state_nxt;
      horner_cnt_r <= horner_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    horner_cnt_nxt = horner_cnt_r;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_X2;
        end
      end
      S_X2: begin
        cmd.mul_sel    = MUL_X2;
        cmd.incr_calc  = 1'b1;
        horner_cnt_nxt = '0;
        state_nxt      = S_HORNER;
      end
      S_HORNER: begin
        cmd.mul_sel       = MUL_HORNER;
        cmd.coef_idx      = horner_cnt_r;
        cmd.ramp_update   = (horner_cnt_r == CNT_W'(0));
        cmd.phase_advance = (horner_cnt_r == CNT_W'(1));
        if (horner_cnt_r == CNT_W'(HORNER_TERMS - 1)) begin
          state_nxt = S_Y;
        end else begin
          horner_cnt_nxt = horner_cnt_r + CNT_W'(1);
        end
      end
      S_Y: begin
        cmd.mul_sel = MUL_Y;
        state_nxt   = S_AMP;
      end
      S_AMP: begin
        cmd.mul_sel = MUL_AMP;
        state_nxt   = S_SL;
      end
      S_SL: begin
        cmd.mul_sel = MUL_SL;
        state_nxt   = S_MUL_L;
      end
      S_MUL_L: begin
        cmd.mul_sel = MUL_LEFT;
        state_nxt   = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.mul_sel  = MUL_RIGHT;
        cmd.sat_left = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_X2))
    else $error("accepted tick did not start the sequence");

  a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !sts.out_free) |=> (state_r == S_OUT))
    else $error("result left the sequencer while output register was busy");

endmodule

`default_nettype wire

/* hdl/rsso_datapath.sv */
// oscillator state, ramp arithmetic, shared multiplier and output register
// depends on rsso_pkg; driven by rsso_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module rsso_datapath import rsso_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data,
  input  logic [STEP_W-1:0]       in_target_step,
  input  logic [LEVEL_W-1:0]      in_target_level,
  input  logic signed [PAN_W-1:0] in_pan_position,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_left_sample,
  output logic signed [OUT_W-1:0] out_right_sample,
  input  dp_cmd_t                 cmd,
  output dp_sts_t                 sts
);

  localparam int SAT_POS = (1 << (OUT_W - 1)) - 1;
  localparam int SAT_NEG = 1 << (OUT_W - 1);

  // architectural state
  logic [CFG_W-1:0]        ramp_shift_r, ramp_shift_nxt;
  logic [PHASE_BITS-1:0]   phase_r, phase_nxt;
  logic [STEP_W-1:0]       cur_step_r, cur_step_nxt;
  logic signed [STEP_W:0]  step_incr_r, step_incr_nxt;
  logic [LEVEL_W-1:0]      cur_level_r, cur_level_nxt;
  logic signed [LEVEL_W:0] level_incr_r, level_incr_nxt;
  logic [STEP_W-1:0]       lat_step_r, lat_step_nxt;
  logic [LEVEL_W-1:0]      lat_level_r, lat_level_nxt;
  logic signed [PAN_W-1:0] lat_pan_r, lat_pan_nxt;
  logic [TICK_W-1:0]       tick_r, tick_nxt;
  logic                    block_start_r, block_start_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // working registers
  logic [VAL_W-1:0]              x_r, x_nxt;
  logic [1:0]                    quad_r, quad_nxt;
  logic [VAL_W-1:0]              x2_r, x2_nxt;
  logic [VAL_W-1:0]              p_r, p_nxt;
  logic [VAL_W-1:0]              y_r, y_nxt;
  logic signed [SAMPLE_BITS-1:0] s_r, s_nxt;
  logic signed [MUL_W-1:0]       sl_r, sl_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [OUT_W-1:0]       left_r, left_nxt;
  logic signed [OUT_W-1:0]       out_left_r, out_left_nxt;
  logic signed [OUT_W-1:0]       out_right_r, out_right_nxt;

  // combinational
  logic [SHIFT_W-1:0]         sh;
  logic [TICK_W:0]            blk_len;
  logic                       last_tick;
  logic [TABLE_ADDR_BITS-1:0] addr;
  logic [QUAD_BITS:0]         q_mir;
  logic                       step_dn, level_dn;
  logic [STEP_W-1:0]          step_mag;
  logic [LEVEL_W-1:0]         level_mag;
  logic signed [GAIN_W-1:0]   gain_l, gain_r;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]          amp_sum;
  logic [VAL_W-1:0]           y_raw;
  logic [SAMPLE_BITS-1:0]     s_mag;

  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PROD_W-1:0] v);
    logic             neg;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rnd;
    logic signed [OUT_W-1:0] r;
    neg = v[PROD_W-1];
    mag = neg ? (PROD_W'(0) - PROD_W'(v)) : PROD_W'(v);
    rnd = (mag + (PROD_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (neg) begin
      r = (rnd > PROD_W'(SAT_NEG)) ? OUT_W'(-SAT_NEG) : OUT_W'(PROD_W'(0) - rnd);
    end else begin
      r = (rnd > PROD_W'(SAT_POS)) ? OUT_W'(SAT_POS) : rnd[OUT_W-1:0];
    end
    return r;
  endfunction

  // block length, saturated shift
  always_comb begin
    if (int'(ramp_shift_r) > MAX_RAMP_SHIFT) begin
      sh = SHIFT_W'(MAX_RAMP_SHIFT);
    end else begin
      sh = SHIFT_W'(ramp_shift_r);
    end
  end

  assign blk_len   = (TICK_W + 1)'(1) << sh;
  assign last_tick = (({1'b0, tick_r}) + (TICK_W + 1)'(1)) >= blk_len;

  // quarter-wave address, mirrored in odd quadrants
  assign addr  = phase_r[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign q_mir = addr[TABLE_ADDR_BITS-2] ?
                 (((QUAD_BITS + 1)'(1) << QUAD_BITS) - {1'b0, addr[QUAD_BITS-1:0]}) :
                 {1'b0, addr[QUAD_BITS-1:0]};

  // ramp increments, magnitude truncated toward zero
  assign step_dn   = lat_step_r < cur_step_r;
  assign step_mag  = (step_dn ? (cur_step_r - lat_step_r) : (lat_step_r - cur_step_r)) >> sh;
  assign level_dn  = lat_level_r < cur_level_r;
  assign level_mag = (level_dn ? (cur_level_r - lat_level_r)
                               : (lat_level_r - cur_level_r)) >> sh;

  assign gain_l = GAIN_W'(HALF_Q15) - GAIN_W'(lat_pan_r);
  assign gain_r = GAIN_W'(HALF_Q15) + GAIN_W'(lat_pan_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_X2: begin
        mul_a = $signed({{(MUL_W - VAL_W){1'b0}}, x_r});
        mul_b = $signed({{(MUL_W - VAL_W){1'b0}}, x_r});
      end
      MUL_HORNER: begin
        mul_a = $signed({{(MUL_W - VAL_W){1'b0}}, p_r});
        mul_b = $signed({{(MUL_W - VAL_W){1'b0}}, x2_r});
      end
      MUL_Y: begin
        mul_a = $signed({{(MUL_W - VAL_W){1'b0}}, p_r});
        mul_b = $signed({{(MUL_W - VAL_W){1'b0}}, x_r});
      end
      MUL_AMP: begin
        mul_a = $signed({{(MUL_W - VAL_W){1'b0}}, y_r});
        mul_b = MUL_W'(SINE_AMP);
      end
      MUL_SL: begin
        mul_a = MUL_W'(s_r);
        mul_b = $signed({{(MUL_W - LEVEL_W){1'b0}}, cur_level_r});
      end
      MUL_LEFT: begin
        mul_a = sl_r;
        mul_b = MUL_W'(gain_l);
      end
      MUL_RIGHT: begin
        mul_a = sl_r;
        mul_b = MUL_W'(gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign amp_sum = PROD_W'(prod) + (PROD_W'(1) << (FRAC - 1));
  assign y_raw   = prod[FRAC +: VAL_W];
  assign s_mag   = amp_sum[FRAC +: SAMPLE_BITS];

  always_comb begin
    ramp_shift_nxt  = ramp_shift_r;
    phase_nxt       = phase_r;
    cur_step_nxt    = cur_step_r;
    step_incr_nxt   = step_incr_r;
    cur_level_nxt   = cur_level_r;
    level_incr_nxt  = level_incr_r;
    lat_step_nxt    = lat_step_r;
    lat_level_nxt   = lat_level_r;
    lat_pan_nxt     = lat_pan_r;
    tick_nxt        = tick_r;
    block_start_nxt = block_start_r;
    out_valid_nxt   = out_valid_r;
    x_nxt           = x_r;
    quad_nxt        = quad_r;
    x2_nxt          = x2_r;
    p_nxt           = p_r;
    y_nxt           = y_r;
    s_nxt           = s_r;
    sl_nxt          = sl_r;
    prod_nxt        = prod_r;
    left_nxt        = left_r;
    out_left_nxt    = out_left_r;
    out_right_nxt   = out_right_r;

    if (cfg_wr_en) begin
      ramp_shift_nxt = cfg_wr_data;
    end

    // tick transfer: sine argument from the phase before this tick
    if (cmd.accept) begin
      x_nxt           = VAL_W'(q_mir) << (FRAC - QUAD_BITS);
      quad_nxt        = addr[TABLE_ADDR_BITS-1 -: 2];
      p_nxt           = HORNER_SEED;
      block_start_nxt = (tick_r == '0);
      if (tick_r == '0) begin
        lat_step_nxt  = in_target_step;
        lat_level_nxt = in_target_level;
        lat_pan_nxt   = in_pan_position;
      end
    end

    if (cmd.incr_calc && block_start_r) begin
      step_incr_nxt  = step_dn ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
      level_incr_nxt = level_dn ? -$signed({1'b0, level_mag}) : $signed({1'b0, level_mag});
    end

    // glide or snap at the block end
    if (cmd.ramp_update) begin
      if (last_tick) begin
        cur_step_nxt  = lat_step_r;
        cur_level_nxt = lat_level_r;
        tick_nxt      = '0;
      end else begin
        cur_step_nxt  = cur_step_r + step_incr_r[STEP_W-1:0];
        cur_level_nxt = cur_level_r + level_incr_r[LEVEL_W-1:0];
        tick_nxt      = tick_r + TICK_W'(1);
      end
    end

    if (cmd.phase_advance) begin
      phase_nxt = phase_r + PHASE_BITS'(cur_step_r);
    end

    case (cmd.mul_sel)
      MUL_X2:     x2_nxt = prod[FRAC +: VAL_W];
      MUL_HORNER: p_nxt  = horner_coef(cmd.coef_idx) - prod[FRAC +: VAL_W];
      MUL_Y:      y_nxt  = (y_raw > ONE_Q30) ? ONE_Q30 : y_raw;
      MUL_AMP:    s_nxt  = quad_r[1] ? -$signed(s_mag) : $signed(s_mag);
      MUL_SL:     sl_nxt = prod[MUL_W-1:0];
      MUL_LEFT:   prod_nxt = prod;
      MUL_RIGHT:  prod_nxt = prod;
      default: begin
      end
    endcase

    if (cmd.sat_left) begin
      left_nxt = round_sat(prod_r);
    end

    // output register, freed by a transfer on the result side
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_left_nxt  = left_r;
      out_right_nxt = round_sat(prod_r);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_shift_r  <= RESET_RAMP_SHIFT;
      phase_r       <= '0;
      cur_step_r    <= RESET_STEP;
      step_incr_r   <= '0;
      cur_level_r   <= RESET_LEVEL;
      level_incr_r  <= '0;
      lat_step_r    <= RESET_STEP;
      lat_level_r   <= RESET_LEVEL;
      lat_pan_r     <= '0;
      tick_r        <= '0;
      block_start_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      ramp_shift_r  <= ramp_shift_nxt;
      phase_r       <= phase_nxt;
      cur_step_r    <= cur_step_nxt;
      step_incr_r   <= step_incr_nxt;
      cur_level_r   <= cur_level_nxt;
      level_incr_r  <= level_incr_nxt;
      lat_step_r    <= lat_step_nxt;
      lat_level_r   <= lat_level_nxt;
      lat_pan_r     <= lat_pan_nxt;
      tick_r        <= tick_nxt;
      block_start_r <= block_start_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    quad_r      <= quad_nxt;
    x2_r        <= x2_nxt;
    p_r         <= p_nxt;
    y_r         <= y_nxt;
    s_r         <= s_nxt;
    sl_r        <= sl_nxt;
    prod_r      <= prod_nxt;
    left_r      <= left_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  assign sts.out_free     = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_left_r;
  assign out_right_sample = out_right_r;

  a_tick_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ramp_update |=> ({1'b0, tick_r} < blk_len))
    else $error("tick counter ran past the ramp block end");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten before transfer");

endmodule

`default_nettype wire

/* hdl/ramped_stereo_sine_oscillator_core.sv */
// top level of the ramped stereo sine oscillator: sequencer plus datapath
// depends on rsso_pkg, rsso_in_if, rsso_out_if, rsso_ctrl, rsso_datapath
//
// usage
//   in_chan carries one sample tick (target_step, target_level, pan_position) and
//   out_chan returns exactly one stereo pair (left_sample, right_sample) per tick.
//   cfg_wr_en / cfg_wr_data write ramp_shift (log2 of the ramp block length);
//   write it only while no tick is in flight.
// timing
//   a tick is taken in the idle state; its pair shows on out_chan once the
//   sequencer has loaded it into the output register in its last step. no new
//   tick is taken before then, as the sine polynomial, the amplitude scale and
//   the three output products run in turn through the single shared multiplier.
// reset
//   rst_n (synchronous, active low) restores phase 0, step 44739243, level 4096,
//   centered pan, ramp_shift 9 and an empty output register.
// backpressure
//   the output register holds a finished pair until out_chan.ready; the next tick
//   is still taken and worked on, and the sequencer waits only in its last step
//   if the previous pair has not been taken yet.
`timescale 1ns / 1ps
`default_nettype none

module ramped_stereo_sine_oscillator_core import rsso_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  rsso_in_if.sink          in_chan,
  rsso_out_if.source       out_chan
);

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: accepts ticks and walks the multiplier schedule
  rsso_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: ramp state, phase accumulator, shared multiplier, output register
  rsso_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_target_step   (in_chan.target_step),
    .in_target_level  (in_chan.target_level),
    .in_pan_position  (in_chan.pan_position),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_left_sample  (out_chan.left_sample),
    .out_right_sample (out_chan.right_sample),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

`default_nettype wire
